// ===== rtl/vlcg_pkg.sv =====
package vlcg_pkg;

   localparam int TABLE_SIDE_DEF   = 64;
   localparam int CHANNEL_BITS_DEF = 16;
   localparam int MAX_DIM_DEF      = 4096;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 8;

   localparam int CH_BITS       = 16;
   localparam int COORD_BITS    = 20;
   localparam int TINDEX_BITS   = 18;
   localparam int DIM_REG_BITS  = 13;
   localparam int STEP_BITS     = 18;
   localparam int REQ_DATA_BITS = 120;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_U_STEP       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_V_STEP       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRADE_ENABLE = 3'd4;

   localparam logic [DIM_REG_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [DIM_REG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [STEP_BITS-1:0]    U_STEP_RST       = 18'd205;
   localparam logic [STEP_BITS-1:0]    V_STEP_RST       = 18'd273;

   // minus one and the positive limit in signed Q4.16
   localparam logic signed [COORD_BITS-1:0] COORD_MINUS_ONE = 20'shF0000;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX       = 20'sh7FFFF;

   typedef struct packed {
      logic [DIM_REG_BITS-1:0] frame_width;
      logic [DIM_REG_BITS-1:0] frame_height;
      logic [STEP_BITS-1:0]    u_step;
      logic [STEP_BITS-1:0]    v_step;
      logic                    grade_enable;
   } cfg_type;

   typedef struct packed {
      logic                         op;
      logic                         eof;
      logic [CH_BITS-1:0]           red;
      logic [CH_BITS-1:0]           green;
      logic [CH_BITS-1:0]           blue;
      logic signed [COORD_BITS-1:0] u_coord;
      logic signed [COORD_BITS-1:0] v_coord;
      logic [TINDEX_BITS-1:0]       tbl_index;
      logic [CH_BITS-1:0]           tbl_red;
      logic [CH_BITS-1:0]           tbl_green;
      logic [CH_BITS-1:0]           tbl_blue;
   } entry_type;

endpackage

// ===== rtl/vlcg_ram.sv =====
module vlcg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/vlcg_fifo.sv =====
module vlcg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/vlcg_front.sv =====
module vlcg_front #(
   parameter int CHANNEL_BITS = 16,
   parameter int MAX_DIM      = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  vlcg_pkg::cfg_type                        cfg,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [vlcg_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   input  logic [vlcg_pkg::REQ_USER_BITS-1:0]       req_tuser,
   output logic                                     q_valid,
   input  logic                                     q_ready,
   output vlcg_pkg::entry_type                      q_data
);
   import vlcg_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_DIM);
   localparam int DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int CMP_BITS = (DIM_BITS > DIM_REG_BITS) ? DIM_BITS : DIM_REG_BITS;
   localparam logic [CH_BITS-1:0] CH_MASK = CH_BITS'((32'd1 << CHANNEL_BITS) - 1);

   logic signed [COORD_BITS-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [COORD_BITS-1:0] u_cur, v_cur, u_sum_sat, v_sum_sat;
   logic signed [COORD_BITS:0]   u_sum, v_sum;
   logic [CNT_BITS-1:0]          col_ff, col_in, row_ff, row_in, col_cur, row_cur;
   logic [CMP_BITS-1:0]          width_eff, height_eff;
   logic                         op, sof, last_col, last_row, accept_pixel;

   function automatic logic [CMP_BITS-1:0] clamp_dim(input logic [DIM_REG_BITS-1:0] d);
      logic [CMP_BITS-1:0] r;
      if (d == '0) begin
         r = CMP_BITS'(1);
      end else if (CMP_BITS'(d) > CMP_BITS'(MAX_DIM)) begin
         r = CMP_BITS'(MAX_DIM);
      end else begin
         r = CMP_BITS'(d);
      end
      return r;
   endfunction

   assign op  = req_tuser[0];
   assign sof = req_tuser[1];

   assign req_tready   = q_ready;
   assign q_valid      = req_tvalid;
   assign accept_pixel = req_tvalid && q_ready && (op == OP_PIXEL);

   // start of frame restarts the position before this pixel
   assign u_cur   = sof ? COORD_MINUS_ONE : u_ff;
   assign v_cur   = sof ? COORD_MINUS_ONE : v_ff;
   assign col_cur = sof ? '0 : col_ff;
   assign row_cur = sof ? '0 : row_ff;

   assign width_eff  = clamp_dim(cfg.frame_width);
   assign height_eff = clamp_dim(cfg.frame_height);
   assign last_col   = CMP_BITS'(col_cur) >= (width_eff - 1'b1);
   assign last_row   = CMP_BITS'(row_cur) >= (height_eff - 1'b1);

   assign u_sum     = (COORD_BITS + 1)'(u_cur) + $signed({3'b000, cfg.u_step});
   assign v_sum     = (COORD_BITS + 1)'(v_cur) + $signed({3'b000, cfg.v_step});
   assign u_sum_sat = (u_sum > (COORD_BITS + 1)'(COORD_MAX)) ? COORD_MAX : u_sum[COORD_BITS-1:0];
   assign v_sum_sat = (v_sum > (COORD_BITS + 1)'(COORD_MAX)) ? COORD_MAX : v_sum[COORD_BITS-1:0];

   always_comb begin
      u_in   = u_ff;
      v_in   = v_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept_pixel) begin
         u_in   = u_cur;
         v_in   = v_cur;
         row_in = row_cur;
         if (last_col) begin
            col_in = '0;
            u_in   = COORD_MINUS_ONE;
            if (last_row) begin
               row_in = '0;
               v_in   = COORD_MINUS_ONE;
            end else begin
               row_in = row_cur + 1'b1;
               v_in   = v_sum_sat;
            end
         end else begin
            col_in = col_cur + 1'b1;
            u_in   = u_sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_ff   <= COORD_MINUS_ONE;
         v_ff   <= COORD_MINUS_ONE;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      q_data.op        = op;
      q_data.eof       = last_col && last_row;
      q_data.red       = req_tdata[15:0] & CH_MASK;
      q_data.green     = req_tdata[31:16] & CH_MASK;
      q_data.blue      = req_tdata[47:32] & CH_MASK;
      q_data.u_coord   = u_cur;
      q_data.v_coord   = v_cur;
      q_data.tbl_index = req_tdata[65:48];
      q_data.tbl_red   = req_tdata[81:66] & CH_MASK;
      q_data.tbl_green = req_tdata[97:82] & CH_MASK;
      q_data.tbl_blue  = req_tdata[113:98] & CH_MASK;
   end

endmodule

// ===== rtl/vlcg_back.sv =====
module vlcg_back #(
   parameter int TABLE_SIDE   = 64,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               grade_enable,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  vlcg_pkg::entry_type                q_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vlcg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import vlcg_pkg::*;

   localparam int ENTRIES   = TABLE_SIDE * TABLE_SIDE * TABLE_SIDE;
   localparam int ADDR_BITS = $clog2(ENTRIES);
   localparam int IDX_BITS  = $clog2(TABLE_SIDE);
   localparam int SIDE_BITS = $clog2(TABLE_SIDE + 1);
   localparam int CP_BITS   = CH_BITS + SIDE_BITS;
   localparam int CR_BITS   = $clog2(OUT_DEPTH + 1);
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int FAC_BITS  = 33;
   localparam int OB_BITS   = RSP_DATA_BITS + 1;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   entry_type            e1_ff, e2_ff, e3_ff;
   logic [SQ_BITS-1:0]   usq_ff, usq_in, vsq_ff, vsq_in;
   logic [FAC_BITS-1:0]  factor_ff, factor_in;
   logic [CH_BITS-1:0]   sc_ff [3];
   logic [CH_BITS-1:0]   sc_in [3];
   logic [CH_BITS-1:0]   ch2 [3];
   logic [IDX_BITS-1:0]  lut_idx [3];
   logic [COORD_BITS-1:0] u_mag, v_mag;
   logic [SQ_BITS:0]     sq_sum;
   logic [SQ_BITS-1:0]   half;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 wr_en, rd_en;
   logic                 op4_ff, eof4_ff, grade4_ff;
   logic [RSP_DATA_BITS-1:0] byp4_ff, rd_data;
   logic [CR_BITS-1:0]   credit_ff, credit_in;
   logic                 pop, pop_pixel, rsp_accept, ob_push, ob_ready;
   logic [OB_BITS-1:0]   ob_in, ob_out;

   // a pixel leaves the queue only with a slot reserved in the output buffer
   assign pop       = q_valid && ((q_data.op == OP_WRITE) || (credit_ff < CR_BITS'(OUT_DEPTH)));
   assign q_ready   = pop;
   assign pop_pixel = pop && (q_data.op == OP_PIXEL);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      credit_in = credit_ff;
      if (pop_pixel && !rsp_accept) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_accept && !pop_pixel) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   // stage 1: squares of the coordinates
   assign u_mag  = q_data.u_coord[COORD_BITS-1] ? COORD_BITS'(-q_data.u_coord)
                                                : COORD_BITS'(q_data.u_coord);
   assign v_mag  = q_data.v_coord[COORD_BITS-1] ? COORD_BITS'(-q_data.v_coord)
                                                : COORD_BITS'(q_data.v_coord);
   assign usq_in = SQ_BITS'(u_mag) * SQ_BITS'(u_mag);
   assign vsq_in = SQ_BITS'(v_mag) * SQ_BITS'(v_mag);

   // stage 2: factor 1 - (u^2 + v^2)/2, clamped at zero
   assign sq_sum    = (SQ_BITS + 1)'(usq_ff) + (SQ_BITS + 1)'(vsq_ff);
   assign half      = sq_sum[SQ_BITS:1];
   assign factor_in = (half >= SQ_BITS'(64'd1 << 32)) ? '0
                    : FAC_BITS'(SQ_BITS'(64'd1 << 32) - half);

   // stage 3: scale each channel
   assign ch2[0] = e2_ff.red;
   assign ch2[1] = e2_ff.green;
   assign ch2[2] = e2_ff.blue;

   always_comb begin
      logic [CH_BITS+FAC_BITS-1:0] prod;
      for (int k = 0; k < 3; k++) begin
         prod     = (CH_BITS + FAC_BITS)'(ch2[k]) * (CH_BITS + FAC_BITS)'(factor_ff);
         sc_in[k] = prod[CH_BITS+31:32];
      end
   end

   // stage 4: nearest table entry, read or write the table
   always_comb begin
      logic [CP_BITS-1:0] cp;
      logic [CP_BITS-1:0] idx;
      for (int k = 0; k < 3; k++) begin
         cp  = CP_BITS'(sc_ff[k]) * CP_BITS'(TABLE_SIDE);
         idx = cp >> CHANNEL_BITS;
         lut_idx[k] = (idx > CP_BITS'(TABLE_SIDE - 1)) ? IDX_BITS'(TABLE_SIDE - 1)
                                                       : IDX_BITS'(idx);
      end
   end

   assign rd_addr = ADDR_BITS'(32'(lut_idx[0]) + TABLE_SIDE * 32'(lut_idx[1])
                               + TABLE_SIDE * TABLE_SIDE * 32'(lut_idx[2]));
   assign rd_en   = v3_ff && (e3_ff.op == OP_PIXEL) && grade_enable;
   assign wr_en   = v3_ff && (e3_ff.op == OP_WRITE) && (32'(e3_ff.tbl_index) < ENTRIES);

   vlcg_ram #(
      .WIDTH (RSP_DATA_BITS),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_BITS'(e3_ff.tbl_index)),
      .wr_data ({e3_ff.tbl_blue, e3_ff.tbl_green, e3_ff.tbl_red}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         credit_ff <= '0;
      end else begin
         v1_ff     <= pop;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff     <= q_data;
      usq_ff    <= usq_in;
      vsq_ff    <= vsq_in;
      e2_ff     <= e1_ff;
      factor_ff <= factor_in;
      e3_ff     <= e2_ff;
      sc_ff     <= sc_in;
      op4_ff    <= e3_ff.op;
      eof4_ff   <= e3_ff.eof;
      grade4_ff <= grade_enable;
      byp4_ff   <= {e3_ff.blue, e3_ff.green, e3_ff.red};
   end

   assign ob_push = v4_ff && (op4_ff == OP_PIXEL);
   assign ob_in   = {eof4_ff, grade4_ff ? rd_data : byp4_ff};

   vlcg_fifo #(
      .WIDTH (OB_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ob_push),
      .in_ready  (ob_ready),
      .in_data   (ob_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (ob_out)
   );

   assign rsp_tdata = ob_out[RSP_DATA_BITS-1:0];
   assign rsp_tlast = ob_out[RSP_DATA_BITS];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CR_BITS'(OUT_DEPTH))
      else $error("reserved output slots exceed the buffer depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ob_push |-> ob_ready)
      else $error("result pushed into a full output buffer");

   a_credit_track: assert property (@(posedge clock) disable iff (reset)
      (pop_pixel && !rsp_accept) |=> (credit_ff == $past(credit_ff) + 1'b1))
      else $error("reservation not counted for a popped pixel");

   a_no_idle_result: assert property (@(posedge clock) disable iff (reset)
      (credit_ff == '0) |-> !rsp_tvalid)
      else $error("result offered with no reservation outstanding");

endmodule

// ===== rtl/vignette_lut_color_grade.sv =====
// Vignette and 3D colour table grading on a pixel stream.
//
// Requests arrive on req_* and are taken when req_tvalid and req_tready are
// both high. req_tuser[0] selects a pixel (0) or a table write (1); req_tuser[1]
// marks the first pixel of a frame and restarts the screen position. A pixel
// gives one result on rsp_*, with rsp_tlast on the last pixel of the frame; a
// table write gives none and lands in the table in request order. The user
// must write registers through csr_* while the stream is idle; not enforced.
//
// A new request is taken every cycle while req_tready is high. A pixel's
// result passes the input queue, the squaring, factor and scaling stages,
// the table read and the output buffer before it can be taken. The table is a
// single 262144 x 48 memory, read once per pixel while grading is enabled.
// When rsp_tready is low, the output buffer fills, the back end holds pixels
// in the queue, and req_tready drops once the queue is full; no result is lost.
// Reset clears the position to the frame origin and loads the register
// defaults (640 x 480, grading on); table contents are undefined until written.
module vignette_lut_color_grade
   #(
      parameter int TABLE_SIDE   = vlcg_pkg::TABLE_SIDE_DEF,
      parameter int CHANNEL_BITS = vlcg_pkg::CHANNEL_BITS_DEF,
      parameter int MAX_DIM      = vlcg_pkg::MAX_DIM_DEF
   ) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red, green, blue, table_index, table_red, table_green, table_blue, zero pad
   input  logic [vlcg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // operation, start_of_frame
   input  logic [vlcg_pkg::REQ_USER_BITS-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_red, out_green, out_blue
   output logic [vlcg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [vlcg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [vlcg_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import vlcg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type fq_data, bq_data;
   logic      fq_valid, fq_ready, bq_valid, bq_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wr_data[DIM_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wr_data[DIM_REG_BITS-1:0];
            CSR_U_STEP:       cfg_in.u_step       = csr_wr_data[STEP_BITS-1:0];
            CSR_V_STEP:       cfg_in.v_step       = csr_wr_data[STEP_BITS-1:0];
            CSR_GRADE_ENABLE: cfg_in.grade_enable = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FRAME_WIDTH_RST;
         cfg_ff.frame_height <= FRAME_HEIGHT_RST;
         cfg_ff.u_step       <= U_STEP_RST;
         cfg_ff.v_step       <= V_STEP_RST;
         cfg_ff.grade_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vlcg_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .MAX_DIM      (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_data     (fq_data)
   );

   vlcg_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   vlcg_back #(
      .TABLE_SIDE   (TABLE_SIDE),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .grade_enable (cfg_ff.grade_enable),
      .q_valid      (bq_valid),
      .q_ready      (bq_ready),
      .q_data       (bq_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
